@@ rtl/dpa_pkg.sv @@
// Shared types, codes and helpers for the directed preferential-attachment edge generator.
// No dependencies; imported by the top level and by the port checker.
`default_nettype none

package dpa_pkg;

	typedef enum logic [2:0] {
		SC_NEW_SOURCE    = 3'd0,
		SC_EXISTING_PAIR = 3'd1,
		SC_NEW_TARGET    = 3'd2,
		SC_NEW_PAIR      = 3'd3,
		SC_SELF_LOOP     = 3'd4
	} scen_t;

	typedef enum logic [2:0] {
		REG_TARGET_EDGES       = 3'd0,
		REG_PROB_NEW_SOURCE    = 3'd1,
		REG_PROB_EXISTING_PAIR = 3'd2,
		REG_PROB_NEW_TARGET    = 3'd3,
		REG_PROB_NEW_PAIR      = 3'd4,
		REG_IN_OFFSET          = 3'd5,
		REG_OUT_OFFSET         = 3'd6
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WCALC,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_DECIDE,
		ST_COPY,
		ST_DIV,
		ST_NODE,
		ST_SLOT_RD,
		ST_SLOT_WR,
		ST_FIN_RD,
		ST_FIN_CAP,
		ST_REJ
	} state_t;

	localparam logic [16:0] DEG_MAX = 17'h1FFFF;

	// One write to a degree store: set to a constant bit or increment.
	typedef struct packed {
		logic en;
		logic inc;
		logic use_dst;
		logic val;
	} deg_op_t;

	typedef struct packed {
		deg_op_t in_op;
		deg_op_t out_op;
	} deg_step_t;

	function automatic logic [16:0] sat_inc(input logic [16:0] d);
		return (d < DEG_MAX) ? d + 17'd1 : d;
	endfunction

	// Degree updates of each scenario, in order, two slots per store.
	function automatic deg_step_t deg_plan(input scen_t s, input logic slot);
		deg_step_t r;
		r = '0;
		case (s)
			SC_NEW_SOURCE: begin
				if (!slot) begin
					r.in_op  = '{en: 1'b1, inc: 1'b1, use_dst: 1'b1, val: 1'b0};
					r.out_op = '{en: 1'b1, inc: 1'b0, use_dst: 1'b0, val: 1'b1};
				end else begin
					r.in_op  = '{en: 1'b1, inc: 1'b0, use_dst: 1'b0, val: 1'b0};
				end
			end
			SC_EXISTING_PAIR: begin
				if (!slot) begin
					r.in_op  = '{en: 1'b1, inc: 1'b1, use_dst: 1'b1, val: 1'b0};
					r.out_op = '{en: 1'b1, inc: 1'b1, use_dst: 1'b0, val: 1'b0};
				end
			end
			SC_NEW_TARGET: begin
				if (!slot) begin
					r.in_op  = '{en: 1'b1, inc: 1'b0, use_dst: 1'b1, val: 1'b1};
					r.out_op = '{en: 1'b1, inc: 1'b0, use_dst: 1'b1, val: 1'b0};
				end else begin
					r.out_op = '{en: 1'b1, inc: 1'b1, use_dst: 1'b0, val: 1'b0};
				end
			end
			SC_NEW_PAIR: begin
				if (!slot) begin
					r.in_op  = '{en: 1'b1, inc: 1'b0, use_dst: 1'b0, val: 1'b0};
					r.out_op = '{en: 1'b1, inc: 1'b0, use_dst: 1'b0, val: 1'b1};
				end else begin
					r.in_op  = '{en: 1'b1, inc: 1'b0, use_dst: 1'b1, val: 1'b1};
					r.out_op = '{en: 1'b1, inc: 1'b0, use_dst: 1'b1, val: 1'b0};
				end
			end
			SC_SELF_LOOP: begin
				if (!slot) begin
					r.in_op  = '{en: 1'b1, inc: 1'b0, use_dst: 1'b1, val: 1'b1};
					r.out_op = '{en: 1'b1, inc: 1'b0, use_dst: 1'b1, val: 1'b1};
				end
			end
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

@@ rtl/directed_pref_attach_edge_gen.sv @@
// Directed preferential-attachment edge generator: edge and degree stores, sequencer, divider.
// Depends on dpa_pkg (codes, degree update plan, saturating increment).
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall  | draw_scenario, draw_target, draw_source
//   out     | output    | out_valid/out_stall| accepted, edge_index, nodes, scenario, degrees
//   cfg     | input     | APB psel/penable   | seven registers at 4*i
//
// One transaction at a time. Each runs one endpoint pick per existing endpoint (weight,
// multiply, decide, then a copy from a stored edge or a divide under the node rule),
// then the degree update slots, a final read and the result capture. A refused
// transaction goes straight to its result. A stalled result holds the last state until taken.
// The divider is 4-bit-per-cycle and the store accesses are single-port.
// Reset seeds edge 0 (0 -> 1) and the degrees of nodes 0 and 1; no clearing pass is run.
// A finished result waits in the output register while the next transaction is taken.
`default_nettype none

module directed_pref_attach_edge_gen import dpa_pkg::*; #(
	parameter int MAX_EDGES = 65536
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [15:0] draw_scenario,
	input  wire logic [31:0] draw_target,
	input  wire logic [31:0] draw_source,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             accepted,
	output logic [15:0]      edge_index,
	output logic [16:0]      source_node,
	output logic [16:0]      target_node,
	output logic [2:0]       scenario,
	output logic [16:0]      source_out_degree,
	output logic [16:0]      target_in_degree,
	output logic             finished,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int AW     = $clog2(MAX_EDGES);
	localparam int CW     = $clog2(MAX_EDGES + 1);
	localparam int ND     = 2 * MAX_EDGES;
	localparam int NAW    = $clog2(ND);
	localparam int NCW    = $clog2(ND + 1);
	localparam int PW     = NCW + 17;
	localparam int DSTEPS = (PW + 3) / 4;
	localparam int DQW    = DSTEPS * 4;
	localparam int DCW    = $clog2(DSTEPS);
	localparam int LW     = (CW > 17) ? CW : 17;
	localparam int EW8    = CW + 8;

	// configuration
	logic [16:0] tgt_edges_q;
	logic [15:0] p_ns_q, p_ep_q, p_nt_q, p_np_q, in_off_q, out_off_q;
	logic        cfg_wr;

	// control
	state_t          state_q, state_nx;
	scen_t           scen_q, scen_in;
	logic            pick_src_q, slot_q;
	logic [DCW-1:0]  dcnt_q;
	logic [CW-1:0]   edge_count_q;
	logic [NCW-1:0]  node_count_q;
	logic [1:0]      in_wr_q, out_wr_q;
	logic            out_valid_q;

	// datapath
	logic [31:0]     draw_t_q, draw_s_q;
	logic [NAW-1:0]  src_q, dst_q;
	logic [PW-1:0]   w_q, p_q;
	logic [63:0]     lowp_q;
	logic            frac_q;
	logic [15:0]     rem_q;
	logic [DQW-1:0]  quo_q;

	// stores
	logic [NAW-1:0]  esrc_mem [MAX_EDGES];
	logic [NAW-1:0]  etgt_mem [MAX_EDGES];
	logic [16:0]     indeg_mem [ND];
	logic [16:0]     outdeg_mem [ND];
	logic [NAW-1:0]  esrc_rd_s1, etgt_rd_s1;
	logic            copy_zero_s1;
	logic [16:0]     in_rd_s1, out_rd_s1;
	logic [NAW-1:0]  in_raddr_s1, out_raddr_s1;

	// result register
	logic        accepted_q, finished_q;
	logic [15:0] edge_index_q;
	logic [16:0] source_node_q, target_node_q, src_deg_q, tgt_deg_q;
	logic [2:0]  scenario_q;

	// combinational
	logic [LW-1:0]   limit;
	logic            at_limit, in_acc, out_free, res_load;
	logic [17:0]     s1, s2, s3, s4;
	logic [15:0]     off_sel, dv;
	logic [31:0]     mul_a, mul_b;
	logic [63:0]     w64, prod, p_sum;
	logic [EW8-1:0]  e8;
	logic            is_copy, c_inc, n_inc;
	logic [PW-1:0]   pq8, cidx, dsub;
	logic [AW-1:0]   eaddr;
	logic [15:0]     rem_nx;
	logic [DQW-1:0]  quo_nx, nidx;
	logic [NAW-1:0]  nres, copy_val, ix0, ix1;
	deg_step_t       step;
	logic [NAW-1:0]  in_addr, out_addr, in_raddr, out_raddr;
	logic [16:0]     in_val, out_val, in_wdata, out_wdata;
	logic            deg_ren, in_we, out_we;
	logic [NCW-1:0]  nc_add;

	function automatic logic [NAW-1:0] node_ix(input logic [NCW:0] n);
		return (n >= (NCW+1)'(ND)) ? NAW'(ND - 1) : n[NAW-1:0];
	endfunction

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_edges_q <= 17'd65536;
			p_ns_q      <= 16'd26870;
			p_ep_q      <= 16'd3277;
			p_nt_q      <= 16'd35388;
			p_np_q      <= 16'd0;
			in_off_q    <= 16'd256;
			out_off_q   <= 16'd256;
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(paddr[4:2]))
				REG_TARGET_EDGES:       tgt_edges_q <= pwdata[16:0];
				REG_PROB_NEW_SOURCE:    p_ns_q      <= pwdata[15:0];
				REG_PROB_EXISTING_PAIR: p_ep_q      <= pwdata[15:0];
				REG_PROB_NEW_TARGET:    p_nt_q      <= pwdata[15:0];
				REG_PROB_NEW_PAIR:      p_np_q      <= pwdata[15:0];
				REG_IN_OFFSET:          in_off_q    <= pwdata[15:0];
				REG_OUT_OFFSET:         out_off_q   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[4:2]))
			REG_TARGET_EDGES:       prdata = 32'(tgt_edges_q);
			REG_PROB_NEW_SOURCE:    prdata = 32'(p_ns_q);
			REG_PROB_EXISTING_PAIR: prdata = 32'(p_ep_q);
			REG_PROB_NEW_TARGET:    prdata = 32'(p_nt_q);
			REG_PROB_NEW_PAIR:      prdata = 32'(p_np_q);
			REG_IN_OFFSET:          prdata = 32'(in_off_q);
			REG_OUT_OFFSET:         prdata = 32'(out_off_q);
			default:                prdata = 32'd0;
		endcase
	end

	// ---------------- scenario choice ----------------
	assign limit    = (LW'(tgt_edges_q) < LW'(MAX_EDGES)) ? LW'(tgt_edges_q) : LW'(MAX_EDGES);
	assign at_limit = LW'(edge_count_q) >= limit;
	assign s1 = 18'(p_ns_q);
	assign s2 = s1 + 18'(p_ep_q);
	assign s3 = s2 + 18'(p_nt_q);
	assign s4 = s3 + 18'(p_np_q);

	always_comb begin
		if (18'(draw_scenario) <= s1)      scen_in = SC_NEW_SOURCE;
		else if (18'(draw_scenario) <= s2) scen_in = SC_EXISTING_PAIR;
		else if (18'(draw_scenario) <= s3) scen_in = SC_NEW_TARGET;
		else if (18'(draw_scenario) <= s4) scen_in = SC_NEW_PAIR;
		else                               scen_in = SC_SELF_LOOP;
	end

	assign ix0 = node_ix({1'b0, node_count_q});
	assign ix1 = node_ix({1'b0, node_count_q} + (NCW+1)'(1));

	// ---------------- endpoint pick ----------------
	assign off_sel = pick_src_q ? out_off_q : in_off_q;
	assign dv      = (off_sel == 16'd0) ? 16'd1 : off_sel;
	assign mul_a   = pick_src_q ? draw_s_q : draw_t_q;
	assign w64     = 64'(w_q);
	assign mul_b   = (state_q == ST_MUL_LO) ? w64[31:0] : w64[63:32];
	assign prod    = mul_a * mul_b;
	assign p_sum   = prod + {32'd0, lowp_q[63:32]};
	assign e8      = {edge_count_q, 8'd0};
	assign is_copy = p_q < PW'(e8);

	// copy branch: index ceil(p/256) - 1, clamped at zero
	assign pq8   = p_q >> 8;
	assign c_inc = (p_q[7:0] != 8'd0) || frac_q;
	assign cidx  = c_inc ? pq8 : ((pq8 == '0) ? '0 : pq8 - PW'(1));
	assign eaddr = cidx[AW-1:0];
	assign copy_val = copy_zero_s1 ? (pick_src_q ? NAW'(0) : NAW'(1))
		: (pick_src_q ? esrc_rd_s1 : etgt_rd_s1);

	// node branch: quotient of the part beyond the edges
	assign dsub  = p_q - PW'(e8);
	assign n_inc = frac_q || (rem_q != 16'd0);
	assign nidx  = n_inc ? quo_q : ((quo_q == '0) ? '0 : quo_q - DQW'(1));
	assign nres  = (nidx >= DQW'(ND)) ? NAW'(ND - 1) : nidx[NAW-1:0];

	// four restoring steps per cycle
	always_comb begin
		logic [15:0]    r;
		logic [DQW-1:0] qq;
		logic [16:0]    t;
		r  = rem_q;
		qq = quo_q;
		t  = '0;
		for (int i = 0; i < 4; i++) begin
			t  = {r, qq[DQW-1]};
			qq = {qq[DQW-2:0], 1'b0};
			if (t >= {1'b0, dv}) begin
				r     = 16'(t - {1'b0, dv});
				qq[0] = 1'b1;
			end else begin
				r = t[15:0];
			end
		end
		rem_nx = r;
		quo_nx = qq;
	end

	// ---------------- degree stores ----------------
	// Slots and the final read run in separate cycles, so a read always sees the prior write.
	assign step      = deg_plan(scen_q, slot_q);
	assign in_addr   = step.in_op.use_dst ? dst_q : src_q;
	assign out_addr  = step.out_op.use_dst ? dst_q : src_q;
	assign in_raddr  = (state_q == ST_FIN_RD) ? dst_q : in_addr;
	assign out_raddr = (state_q == ST_FIN_RD) ? src_q : out_addr;
	assign deg_ren   = (state_q == ST_SLOT_RD) || (state_q == ST_FIN_RD);
	assign in_we     = (state_q == ST_SLOT_WR) && step.in_op.en;
	assign out_we    = (state_q == ST_SLOT_WR) && step.out_op.en;

	// nodes 0 and 1 read their seed value until first written
	always_comb begin
		if (in_raddr_s1 == NAW'(0) && !in_wr_q[0])      in_val = 17'd0;
		else if (in_raddr_s1 == NAW'(1) && !in_wr_q[1]) in_val = 17'd1;
		else                                            in_val = in_rd_s1;
		if (out_raddr_s1 == NAW'(0) && !out_wr_q[0])      out_val = 17'd1;
		else if (out_raddr_s1 == NAW'(1) && !out_wr_q[1]) out_val = 17'd0;
		else                                              out_val = out_rd_s1;
	end

	assign in_wdata  = step.in_op.inc ? sat_inc(in_val) : {16'd0, step.in_op.val};
	assign out_wdata = step.out_op.inc ? sat_inc(out_val) : {16'd0, step.out_op.val};

	always_ff @(posedge clk) begin
		if (in_we) indeg_mem[in_addr] <= in_wdata;
		if (out_we) outdeg_mem[out_addr] <= out_wdata;
		if (deg_ren) begin
			in_rd_s1     <= indeg_mem[in_raddr];
			out_rd_s1    <= outdeg_mem[out_raddr];
			in_raddr_s1  <= in_raddr;
			out_raddr_s1 <= out_raddr;
		end
	end

	// ---------------- edge stores ----------------
	always_ff @(posedge clk) begin
		if (state_q == ST_FIN_RD) begin
			esrc_mem[edge_count_q[AW-1:0]] <= src_q;
			etgt_mem[edge_count_q[AW-1:0]] <= dst_q;
		end
		if (state_q == ST_DECIDE && is_copy) begin
			esrc_rd_s1   <= esrc_mem[eaddr];
			etgt_rd_s1   <= etgt_mem[eaddr];
			copy_zero_s1 <= (eaddr == '0);
		end
	end

	// ---------------- sequencer ----------------
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign res_load = ((state_q == ST_FIN_CAP) || (state_q == ST_REJ)) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_nx;
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (at_limit) state_nx = ST_REJ;
					else if (scen_in == SC_NEW_SOURCE || scen_in == SC_EXISTING_PAIR
						|| scen_in == SC_NEW_TARGET) state_nx = ST_WCALC;
					else state_nx = ST_SLOT_RD;
				end
			end
			ST_WCALC:  state_nx = ST_MUL_LO;
			ST_MUL_LO: state_nx = ST_MUL_HI;
			ST_MUL_HI: state_nx = ST_DECIDE;
			ST_DECIDE: state_nx = is_copy ? ST_COPY : ST_DIV;
			ST_DIV:    state_nx = (dcnt_q == DCW'(DSTEPS - 1)) ? ST_NODE : ST_DIV;
			ST_COPY, ST_NODE: begin
				if (!pick_src_q && scen_q == SC_EXISTING_PAIR) state_nx = ST_WCALC;
				else state_nx = ST_SLOT_RD;
			end
			ST_SLOT_RD: state_nx = ST_SLOT_WR;
			ST_SLOT_WR: state_nx = slot_q ? ST_FIN_RD : ST_SLOT_RD;
			ST_FIN_RD:  state_nx = ST_FIN_CAP;
			ST_FIN_CAP, ST_REJ: state_nx = out_free ? ST_IDLE : state_q;
			default:    state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		case (scen_q)
			SC_NEW_PAIR:      nc_add = NCW'(2);
			SC_EXISTING_PAIR: nc_add = NCW'(0);
			default:          nc_add = NCW'(1);
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scen_q       <= SC_NEW_SOURCE;
			pick_src_q   <= 1'b0;
			slot_q       <= 1'b0;
			dcnt_q       <= '0;
			edge_count_q <= CW'(1);
			node_count_q <= NCW'(2);
			in_wr_q      <= 2'b00;
			out_wr_q     <= 2'b00;
			out_valid_q  <= 1'b0;
		end else begin
			if (in_acc) begin
				scen_q     <= scen_in;
				pick_src_q <= (scen_in == SC_NEW_TARGET);
				slot_q     <= 1'b0;
			end
			if ((state_q == ST_COPY || state_q == ST_NODE) && !pick_src_q
				&& scen_q == SC_EXISTING_PAIR) begin
				pick_src_q <= 1'b1;
			end
			if (state_q == ST_DECIDE) dcnt_q <= '0;
			else if (state_q == ST_DIV) dcnt_q <= dcnt_q + DCW'(1);
			if (state_q == ST_SLOT_WR) slot_q <= 1'b1;
			if (in_we && in_addr == NAW'(0)) in_wr_q[0] <= 1'b1;
			if (in_we && in_addr == NAW'(1)) in_wr_q[1] <= 1'b1;
			if (out_we && out_addr == NAW'(0)) out_wr_q[0] <= 1'b1;
			if (out_we && out_addr == NAW'(1)) out_wr_q[1] <= 1'b1;
			if (state_q == ST_FIN_RD) begin
				edge_count_q <= edge_count_q + CW'(1);
				node_count_q <= node_count_q + nc_add;
			end
			if (res_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			draw_t_q <= draw_target;
			draw_s_q <= draw_source;
			unique case (scen_in)
				SC_NEW_SOURCE: src_q <= ix0;
				SC_NEW_TARGET: dst_q <= ix0;
				SC_NEW_PAIR: begin
					src_q <= ix0;
					dst_q <= ix1;
				end
				SC_SELF_LOOP: begin
					src_q <= ix0;
					dst_q <= ix0;
				end
				default: ;
			endcase
		end
		if (state_q == ST_WCALC)
			w_q <= PW'(e8) + PW'(node_count_q) * PW'(off_sel);
		if (state_q == ST_MUL_LO) lowp_q <= prod;
		if (state_q == ST_MUL_HI) begin
			p_q    <= p_sum[PW-1:0];
			frac_q <= (lowp_q[31:0] != 32'd0);
		end
		if (state_q == ST_DECIDE) begin
			rem_q <= 16'd0;
			quo_q <= DQW'(dsub);
		end else if (state_q == ST_DIV) begin
			rem_q <= rem_nx;
			quo_q <= quo_nx;
		end
		if (state_q == ST_COPY || state_q == ST_NODE) begin
			if (pick_src_q) src_q <= (state_q == ST_COPY) ? copy_val : nres;
			else            dst_q <= (state_q == ST_COPY) ? copy_val : nres;
		end
		if (res_load) begin
			if (state_q == ST_FIN_CAP) begin
				accepted_q    <= 1'b1;
				edge_index_q  <= 16'(edge_count_q - CW'(1));
				source_node_q <= 17'(src_q);
				target_node_q <= 17'(dst_q);
				scenario_q    <= scen_q;
				src_deg_q     <= out_val;
				tgt_deg_q     <= in_val;
				finished_q    <= (LW'(edge_count_q) == limit);
			end else begin
				accepted_q    <= 1'b0;
				edge_index_q  <= 16'd0;
				source_node_q <= 17'd0;
				target_node_q <= 17'd0;
				scenario_q    <= 3'd0;
				src_deg_q     <= 17'd0;
				tgt_deg_q     <= 17'd0;
				finished_q    <= 1'b1;
			end
		end
	end

	assign out_valid         = out_valid_q;
	assign accepted          = accepted_q;
	assign edge_index        = edge_index_q;
	assign source_node       = source_node_q;
	assign target_node       = target_node_q;
	assign scenario          = scenario_q;
	assign source_out_degree = src_deg_q;
	assign target_in_degree  = tgt_deg_q;
	assign finished          = finished_q;

endmodule

`default_nettype wire

@@ rtl/dpa_checker.sv @@
// Port-level checker for the edge generator, bound to the top level.
// Depends on dpa_pkg for scenario codes.
`default_nettype none

module dpa_checker import dpa_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic [15:0] draw_scenario,
	input wire logic [31:0] draw_target,
	input wire logic [31:0] draw_source,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic        accepted,
	input wire logic [15:0] edge_index,
	input wire logic [16:0] source_node,
	input wire logic [16:0] target_node,
	input wire logic [2:0]  scenario,
	input wire logic [16:0] source_out_degree,
	input wire logic [16:0] target_in_degree,
	input wire logic        finished,
	input wire logic        psel,
	input wire logic        penable,
	input wire logic        pwrite,
	input wire logic [4:0]  paddr,
	input wire logic [31:0] pwdata,
	input wire logic [31:0] prdata,
	input wire logic        pready
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(source_node)
			&& $stable(target_node) && $stable(edge_index) && $stable(accepted))
		else $error("stalled result changed");

	a_reject_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !accepted |-> finished && source_node == 17'd0
			&& target_node == 17'd0 && source_out_degree == 17'd0)
		else $error("rejected transaction carries edge data");

	a_self_loop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && accepted && scenario == SC_SELF_LOOP |->
			source_node == target_node && source_out_degree == 17'd1
			&& target_in_degree == 17'd1)
		else $error("self-loop result inconsistent");

	a_new_source: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && accepted && scenario == SC_NEW_SOURCE && source_node != target_node
			|-> source_out_degree == 17'd1 && target_in_degree != 17'd0)
		else $error("new-source degrees wrong");

endmodule

bind directed_pref_attach_edge_gen dpa_checker u_dpa_checker (.*);

`default_nettype wire
